/* sv/sha1_message_digest_top_defines.svh */
// Assertion macros shared by the SHA-1 digest checker
`ifndef SHA1_MESSAGE_DIGEST_TOP_DEFINES_SVH
`define SHA1_MESSAGE_DIGEST_TOP_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define SHA1MD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sha1md check failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define SHA1MD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sha1md check failed");

`endif

/* sv/sha1md_pkg.sv */
// Shared types and constants of the SHA-1 digest block
`default_nettype none
package sha1md_pkg;

    localparam int WORD_W      = 32;
    localparam int CNT_W       = 6;
    localparam int LEN_W       = 64;
    localparam int CHAIN_N     = 5;
    localparam int BLOCK_WORDS = 16;
    localparam int FILL_W      = $clog2(BLOCK_WORDS);
    localparam int ROUNDS      = 80;
    localparam int ROUND_W     = $clog2(ROUNDS);
    localparam int PHASE_LEN   = 20;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int OUT_IDX_W   = $clog2(CHAIN_N);

    typedef logic [WORD_W-1:0] t_word;

    // Initial chaining value H0..H4
    localparam t_word H_INIT [CHAIN_N] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };

    // Round constants, one per group of twenty rounds
    localparam t_word K_ROUND [4] = '{
        32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc, 32'hca62c1d6
    };

    localparam t_word             PAD_WORD  = 32'h80000000;
    localparam logic [CNT_W-1:0]  FULL_BITS = 6'd32;
    localparam logic [FILL_W-1:0] LEN_POS   = FILL_W'(BLOCK_WORDS - 2);

    // One word moving from the front to the compression engine
    typedef struct packed {
        t_word word;
        logic  is_final;
    } t_q_entry;

    typedef struct packed {
        logic     valid;
        t_q_entry entry;
    } t_q_push;

endpackage
`default_nettype wire

/* sv/sha1md_if.sv */
// Valid/ready channel interfaces for message words and digest words
`default_nettype none
interface sha1md_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] message_word;
    logic [5:0]  bit_count;
    logic        last_word;

    modport source (output valid, output message_word, output bit_count,
                    output last_word, input ready);
    modport sink   (input valid, input message_word, input bit_count,
                    input last_word, output ready);
endinterface

interface sha1md_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic        digest_last;

    modport source (output valid, output digest_word, output digest_last, input ready);
    modport sink   (input valid, input digest_word, input digest_last, output ready);
endinterface
`default_nettype wire

/* sv/sha1md_front.sv */
// Front end: takes message words, tracks length, emits padding and length words
`default_nettype none
module sha1md_front (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    sha1md_in_if.sink                 i_msg,
    output sha1md_pkg::t_q_push       o_push,
    input  wire                       i_q_full
);

    typedef enum logic [1:0] {F_IDLE, F_PAD, F_ZERO, F_LEN_LO} t_fstate;

    t_fstate                            r_state, n_state;
    logic [sha1md_pkg::FILL_W-1:0]      r_pos;
    logic [sha1md_pkg::LEN_W-1:0]       r_total, n_total;
    logic [sha1md_pkg::CNT_W-1:0]       n_bits;
    sha1md_pkg::t_word                  last_mask;
    sha1md_pkg::t_word                  last_data;
    logic                               accept;

    // Clamp the bit count and close the final word with its pad bit
    always_comb begin
        n_bits    = (i_msg.bit_count > sha1md_pkg::FULL_BITS) ? sha1md_pkg::FULL_BITS
                                                              : i_msg.bit_count;
        last_mask = ~(32'hffffffff >> n_bits);
        last_data = (i_msg.message_word & last_mask) | (sha1md_pkg::PAD_WORD >> n_bits);
    end

    assign i_msg.ready = (r_state == F_IDLE) && !i_q_full;
    assign accept      = i_msg.valid && i_msg.ready;

    // Pick the next word to queue and the next state
    always_comb begin
        n_state        = r_state;
        n_total        = r_total;
        o_push.valid   = 1'b0;
        o_push.entry   = '0;
        case (r_state)
            F_IDLE: begin
                if (accept) begin
                    o_push.valid = 1'b1;
                    if (!i_msg.last_word) begin
                        o_push.entry.word = i_msg.message_word;
                        n_total = r_total + sha1md_pkg::LEN_W'(sha1md_pkg::WORD_W);
                    end else begin
                        n_total = r_total + sha1md_pkg::LEN_W'(n_bits);
                        if (n_bits == sha1md_pkg::FULL_BITS) begin
                            o_push.entry.word = i_msg.message_word;
                            n_state = F_PAD;
                        end else begin
                            o_push.entry.word = last_data;
                            n_state = F_ZERO;
                        end
                    end
                end
            end
            F_PAD: begin
                if (!i_q_full) begin
                    o_push.valid      = 1'b1;
                    o_push.entry.word = sha1md_pkg::PAD_WORD;
                    n_state           = F_ZERO;
                end
            end
            F_ZERO: begin
                if (!i_q_full) begin
                    o_push.valid = 1'b1;
                    if (r_pos == sha1md_pkg::LEN_POS) begin
                        o_push.entry.word = r_total[sha1md_pkg::LEN_W-1:sha1md_pkg::WORD_W];
                        n_state = F_LEN_LO;
                    end
                end
            end
            F_LEN_LO: begin
                if (!i_q_full) begin
                    o_push.valid          = 1'b1;
                    o_push.entry.word     = r_total[sha1md_pkg::WORD_W-1:0];
                    o_push.entry.is_final = 1'b1;
                    n_total               = '0;
                    n_state               = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    // Hold state, block position and running length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_pos   <= '0;
            r_total <= '0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            if (o_push.valid) begin
                r_pos <= r_pos + 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

/* sv/sha1md_queue.sv */
// Short word queue between the front end and the compression engine
`default_nettype none
module sha1md_queue (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  sha1md_pkg::t_q_push       i_push,
    input  wire                       i_pop,
    output sha1md_pkg::t_q_entry      o_head,
    output logic                      o_full,
    output logic                      o_empty
);

    sha1md_pkg::t_q_entry               r_mem [sha1md_pkg::QUEUE_DEPTH];
    logic [sha1md_pkg::QPTR_W-1:0]      r_wr_ptr;
    logic [sha1md_pkg::QPTR_W-1:0]      r_rd_ptr;
    logic [sha1md_pkg::QPTR_W:0]        r_count;

    assign o_head  = r_mem[r_rd_ptr];
    assign o_full  = (r_count == (sha1md_pkg::QPTR_W + 1)'(sha1md_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);

    // Store on push, advance pointers, track fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_mem[r_wr_ptr] <= i_push.entry;
                r_wr_ptr        <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push.valid, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

/* sv/sha1md_back.sv */
// Compression engine: loads 16 words, runs 80 rounds, updates, and after the final block sends the digest
`default_nettype none
module sha1md_back (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  sha1md_pkg::t_q_entry      i_head,
    input  wire                       i_q_empty,
    output logic                      o_pop,
    sha1md_out_if.source              o_digest
);

    typedef enum logic [1:0] {B_LOAD, B_ROUND, B_UPDATE, B_OUT} t_bstate;

    t_bstate                            r_state;
    sha1md_pkg::t_word                  r_chain [sha1md_pkg::CHAIN_N];
    sha1md_pkg::t_word                  r_wv    [sha1md_pkg::CHAIN_N];
    sha1md_pkg::t_word                  r_sched [sha1md_pkg::BLOCK_WORDS];
    logic [sha1md_pkg::FILL_W-1:0]      r_fill;
    logic [sha1md_pkg::ROUND_W-1:0]     r_round;
    logic                               r_final;
    logic [sha1md_pkg::OUT_IDX_W-1:0]   r_out_idx;
    logic                               r_out_valid;
    sha1md_pkg::t_word                  r_out_word;
    logic                               r_out_last;

    sha1md_pkg::t_word                  w_mix;
    sha1md_pkg::t_word                  w_cur;
    sha1md_pkg::t_word                  f_val;
    sha1md_pkg::t_word                  t_sum;
    logic [1:0]                         phase;
    logic                               out_load;

    assign o_pop             = (r_state == B_LOAD) && !i_q_empty;
    assign out_load          = (r_state == B_OUT) && (!r_out_valid || o_digest.ready);
    assign o_digest.valid       = r_out_valid;
    assign o_digest.digest_word = r_out_word;
    assign o_digest.digest_last = r_out_last;

    // One round: schedule word, round function and the five-term sum
    always_comb begin
        w_mix = r_sched[13] ^ r_sched[8] ^ r_sched[2] ^ r_sched[0];
        w_cur = (r_round < sha1md_pkg::ROUND_W'(sha1md_pkg::BLOCK_WORDS))
                ? r_sched[0] : {w_mix[30:0], w_mix[31]};
        if (r_round < sha1md_pkg::ROUND_W'(sha1md_pkg::PHASE_LEN)) begin
            phase = 2'd0;
        end else if (r_round < sha1md_pkg::ROUND_W'(2 * sha1md_pkg::PHASE_LEN)) begin
            phase = 2'd1;
        end else if (r_round < sha1md_pkg::ROUND_W'(3 * sha1md_pkg::PHASE_LEN)) begin
            phase = 2'd2;
        end else begin
            phase = 2'd3;
        end
        case (phase)
            2'd0:    f_val = (r_wv[1] & r_wv[2]) | (~r_wv[1] & r_wv[3]);
            2'd2:    f_val = (r_wv[1] & r_wv[2]) | (r_wv[1] & r_wv[3]) | (r_wv[2] & r_wv[3]);
            default: f_val = r_wv[1] ^ r_wv[2] ^ r_wv[3];
        endcase
        t_sum = {r_wv[0][26:0], r_wv[0][31:27]} + f_val + r_wv[4]
                + sha1md_pkg::K_ROUND[phase] + w_cur;
    end

    // Hold state, chaining value, schedule and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_LOAD;
            r_fill      <= '0;
            r_round     <= '0;
            r_final     <= 1'b0;
            r_out_idx   <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < sha1md_pkg::CHAIN_N; i++) begin
                r_chain[i] <= sha1md_pkg::H_INIT[i];
            end
        end else begin
            // drop the output word once taken
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_digest.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                B_LOAD: begin
                    if (o_pop) begin
                        for (int i = 0; i < sha1md_pkg::BLOCK_WORDS - 1; i++) begin
                            r_sched[i] <= r_sched[i+1];
                        end
                        r_sched[sha1md_pkg::BLOCK_WORDS-1] <= i_head.word;
                        r_fill <= r_fill + 1'b1;
                        if (i_head.is_final) begin
                            r_final <= 1'b1;
                        end
                        if (r_fill == sha1md_pkg::FILL_W'(sha1md_pkg::BLOCK_WORDS - 1)) begin
                            r_wv    <= r_chain;
                            r_round <= '0;
                            r_state <= B_ROUND;
                        end
                    end
                end
                B_ROUND: begin
                    for (int i = 0; i < sha1md_pkg::BLOCK_WORDS - 1; i++) begin
                        r_sched[i] <= r_sched[i+1];
                    end
                    r_sched[sha1md_pkg::BLOCK_WORDS-1] <= w_cur;
                    r_wv[4] <= r_wv[3];
                    r_wv[3] <= r_wv[2];
                    r_wv[2] <= {r_wv[1][1:0], r_wv[1][31:2]};
                    r_wv[1] <= r_wv[0];
                    r_wv[0] <= t_sum;
                    r_round <= r_round + 1'b1;
                    if (r_round == sha1md_pkg::ROUND_W'(sha1md_pkg::ROUNDS - 1)) begin
                        r_state <= B_UPDATE;
                    end
                end
                B_UPDATE: begin
                    for (int i = 0; i < sha1md_pkg::CHAIN_N; i++) begin
                        r_chain[i] <= r_chain[i] + r_wv[i];
                    end
                    r_out_idx <= '0;
                    r_state   <= r_final ? B_OUT : B_LOAD;
                end
                B_OUT: begin
                    if (out_load) begin
                        r_out_word <= r_chain[r_out_idx];
                        r_out_last <= (r_out_idx ==
                                       sha1md_pkg::OUT_IDX_W'(sha1md_pkg::CHAIN_N - 1));
                        r_out_idx  <= r_out_idx + 1'b1;
                        if (r_out_idx == sha1md_pkg::OUT_IDX_W'(sha1md_pkg::CHAIN_N - 1)) begin
                            // restart the chain for the next message
                            for (int i = 0; i < sha1md_pkg::CHAIN_N; i++) begin
                                r_chain[i] <= sha1md_pkg::H_INIT[i];
                            end
                            r_final <= 1'b0;
                            r_state <= B_LOAD;
                        end
                    end
                end
                default: r_state <= B_LOAD;
            endcase
        end
    end

endmodule
`default_nettype wire

/* sv/sha1_message_digest_top.sv */
// Per block: load 16 words, run 80 rounds, update; the last block then sends 5 digest words.
// Compression runs one round per cycle, and the engine takes no new words before the
//   update ends; padding closes the last block and adds one more block when the 64-bit
//   length no longer fits behind the final word.
// A 4-entry word queue lets the front end take words while the engine compresses.
// Reset (i_rst_n low, synchronous) clears length, queue and engine, loads H0..H4.
`default_nettype none
module sha1_message_digest_top (
    input  wire             i_clk,
    input  wire             i_rst_n,
    sha1md_in_if.sink       i_msg,
    sha1md_out_if.source    o_digest
);

    sha1md_pkg::t_q_push    q_push;
    sha1md_pkg::t_q_entry   q_head;
    logic                   q_full;
    logic                   q_empty;
    logic                   q_pop;

    // Classify and pad incoming words
    sha1md_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_msg    (i_msg),
        .o_push   (q_push),
        .i_q_full (q_full)
    );

    // Decouple front and engine
    sha1md_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Compress blocks and send the digest
    sha1md_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (q_head),
        .i_q_empty (q_empty),
        .o_pop     (q_pop),
        .o_digest  (o_digest)
    );

endmodule
`default_nettype wire

/* sv/sha1md_checker.sv */
// Port-level checks on the SHA-1 digest block and their bind
`default_nettype none
`include "sha1_message_digest_top_defines.svh"
module sha1md_checker (
    input wire          i_clk,
    input wire          i_rst_n,
    input wire          i_in_valid,
    input wire          i_in_ready,
    input wire          i_in_last,
    input wire          i_out_valid,
    input wire          i_out_ready,
    input wire [31:0]   i_out_word,
    input wire          i_out_last
);

    logic [2:0] r_word_cnt;
    logic [3:0] r_pending;
    logic       in_end;
    logic       out_end;

    assign in_end  = i_in_valid && i_in_ready && i_in_last;
    assign out_end = i_out_valid && i_out_ready && i_out_last;

    // Count digest words in the current digest and messages still owed a digest
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_cnt <= '0;
            r_pending  <= '0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                r_word_cnt <= i_out_last ? 3'd0 : r_word_cnt + 3'd1;
            end
            case ({in_end, out_end})
                2'b10:   r_pending <= r_pending + 4'd1;
                2'b01:   r_pending <= r_pending - 4'd1;
                default: r_pending <= r_pending;
            endcase
        end
    end

    `SHA1MD_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_word) && $stable(i_out_last))
    `SHA1MD_ASSERT_IMP(a_last_on_fifth, i_out_valid && i_out_ready, i_out_last == (r_word_cnt == 3'd4))
    `SHA1MD_ASSERT_IMP(a_digest_owed, i_out_valid, r_pending != 4'd0)

endmodule

bind sha1_message_digest_top sha1md_checker u_sha1md_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_msg.valid),
    .i_in_ready  (i_msg.ready),
    .i_in_last   (i_msg.last_word),
    .i_out_valid (o_digest.valid),
    .i_out_ready (o_digest.ready),
    .i_out_word  (o_digest.digest_word),
    .i_out_last  (o_digest.digest_last)
);
`default_nettype wire
